/* design/assert_macros.svh */
// Assertion macros shared by the comet chase RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcc: same-cycle check failed");

`define LCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcc: next-cycle check failed");

`else

`define LCC_ASSERT_IMP(lbl, ante, cons)

`define LCC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/lcc_pkg.sv */
// Shared types, constants and the LED remap table for the comet chase block.
// No dependencies.
package lcc_pkg;

  localparam int LEVEL_W    = 16;
  localparam int FADE_W     = 15;
  localparam int PROD_W     = LEVEL_W + FADE_W;
  localparam int PHASE_W    = 8;
  localparam int POS_W      = 4;
  localparam int GREEN_W    = 8;
  localparam int LIDX_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'h8000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_MULTIPLIER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THRESHOLD  = 2'd3;

  localparam logic [PHASE_W-1:0] STEP_PERIOD_RST     = 8'd8;
  localparam logic [PHASE_W-1:0] PAUSE_LENGTH_RST    = 8'd20;
  localparam logic [FADE_W-1:0]  FADE_MULTIPLIER_RST = 15'd27853;
  localparam logic [FADE_W-1:0]  ZERO_THRESHOLD_RST  = 15'd328;

  localparam int MAP_SIZE = 11;
  localparam logic [POS_W-1:0] LED_REMAP [MAP_SIZE] =
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd10};

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_ISSUE,
    SW_FLUSH,
    SW_FINISH
  } sweep_state_t;

  typedef struct packed {
    logic light_en;
    logic clear;
  } tick_ctl_t;

  typedef struct packed {
    logic done;
    logic any_lit;
  } sweep_stat_t;

  // Physical position of a logical LED; indexes past the table map to their low POS_W bits.
  function automatic logic [POS_W-1:0] remap_pos(input logic [LIDX_W-1:0] idx);
    if (idx < LIDX_W'(MAP_SIZE)) begin
      return LED_REMAP[idx[3:0]];
    end
    return idx[POS_W-1:0];
  endfunction

endpackage

/* design/lcc_trail_mem.sv */
// Trail level storage: one synchronous RAM, one write and one registered read port.
// Depends on lcc_pkg.
module lcc_trail_mem import lcc_pkg::*; #(
  parameter int DEPTH  = 11,
  parameter int ADDR_W = 4
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [LEVEL_W-1:0] rd_data_r,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [LEVEL_W-1:0] wr_data
);

  logic [LEVEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* design/lcc_head_ctl.sv */
// Head, phase and pause control of the comet; decides per tick which LED is lit.
// Depends on lcc_pkg.
module lcc_head_ctl import lcc_pkg::*; #(
  parameter int LED_COUNT = 11,
  parameter int HEAD_W    = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               restart,
  input  logic [PHASE_W-1:0] step_period,
  input  logic [PHASE_W-1:0] pause_length,
  input  sweep_stat_t        stat,
  output tick_ctl_t          ctl_r,
  output logic [HEAD_W-1:0]  light_idx_r
);

  logic [HEAD_W-1:0]  head_r, head_nxt;
  logic               waiting_r, waiting_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PHASE_W-1:0] pause_r, pause_nxt;
  logic               fresh_r, fresh_nxt;
  logic               tick_waits_r, tick_waits_nxt;
  tick_ctl_t          ctl_nxt;
  logic [HEAD_W-1:0]  light_idx_nxt;

  logic               clr;
  logic               w0;
  logic [HEAD_W-1:0]  h0;
  logic [PHASE_W-1:0] p0;
  logic [PHASE_W-1:0] q0;
  logic [PHASE_W-1:0] phase_inc;
  logic [HEAD_W-1:0]  head_inc;

  always_comb begin
    clr       = restart | fresh_r;
    w0        = clr ? 1'b0 : waiting_r;
    h0        = clr ? '0 : head_r;
    p0        = clr ? '0 : phase_r;
    q0        = clr ? '0 : pause_r;
    phase_inc = p0 + PHASE_W'(1);
    head_inc  = h0 + HEAD_W'(1);

    head_nxt       = head_r;
    waiting_nxt    = waiting_r;
    phase_nxt      = phase_r;
    pause_nxt      = pause_r;
    fresh_nxt      = fresh_r;
    tick_waits_nxt = tick_waits_r;
    ctl_nxt        = ctl_r;
    light_idx_nxt  = light_idx_r;

    if (start) begin
      fresh_nxt      = 1'b0;
      tick_waits_nxt = w0;
      pause_nxt      = q0;
      ctl_nxt.clear  = clr;
      if (!w0) begin
        head_nxt    = h0;
        waiting_nxt = 1'b0;
        phase_nxt   = phase_inc;
        if (phase_inc >= step_period) begin
          phase_nxt = '0;
          if (head_inc >= HEAD_W'(LED_COUNT)) begin
            head_nxt    = HEAD_W'(LED_COUNT);
            waiting_nxt = 1'b1;
          end else begin
            head_nxt = head_inc;
          end
        end
        ctl_nxt.light_en = !waiting_nxt;
        light_idx_nxt    = head_nxt;
      end else begin
        head_nxt         = h0;
        waiting_nxt      = 1'b1;
        phase_nxt        = p0;
        ctl_nxt.light_en = 1'b0;
      end
    end else if (stat.done && tick_waits_r && !stat.any_lit) begin
      // Trail is dark: count out the pause, then restart from LED 0
      if (pause_r < pause_length) begin
        pause_nxt = pause_r + PHASE_W'(1);
      end else begin
        waiting_nxt = 1'b0;
        head_nxt    = '0;
        phase_nxt   = '0;
        pause_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      waiting_r    <= 1'b0;
      phase_r      <= '0;
      pause_r      <= '0;
      fresh_r      <= 1'b1;
      tick_waits_r <= 1'b0;
      ctl_r        <= '0;
      light_idx_r  <= '0;
    end else begin
      head_r       <= head_nxt;
      waiting_r    <= waiting_nxt;
      phase_r      <= phase_nxt;
      pause_r      <= pause_nxt;
      fresh_r      <= fresh_nxt;
      tick_waits_r <= tick_waits_nxt;
      ctl_r        <= ctl_nxt;
      light_idx_r  <= light_idx_nxt;
    end
  end

endmodule

/* design/lcc_sweep.sv */
// Per-tick sweep over the trail RAM: read, fade, threshold, light head, write back, emit.
// Depends on lcc_pkg and lcc_trail_mem.
module lcc_sweep import lcc_pkg::*; #(
  parameter int LED_COUNT = 11,
  parameter int IDX_W     = 4,
  parameter int HEAD_W    = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tick_ctl_t          ctl,
  input  logic [HEAD_W-1:0]  light_idx,
  input  logic [FADE_W-1:0]  fade_mult,
  input  logic [FADE_W-1:0]  zero_thr,
  input  logic               out_ready,
  output logic               out_valid_r,
  output logic [POS_W-1:0]   out_pos_r,
  output logic [GREEN_W-1:0] out_green_r,
  output logic               out_last_r,
  output sweep_stat_t        stat,
  output logic               busy
);

  sweep_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]   issue_idx_r, issue_idx_nxt;
  logic               v1_r;
  logic [IDX_W-1:0]   idx1_r;
  logic               v2_r;
  logic [IDX_W-1:0]   idx2_r;
  logic [PROD_W-1:0]  prod_r;
  logic               any_lit_r;

  logic               adv;
  logic               rd_en;
  logic               last_issue;
  logic               last2;
  logic [LEVEL_W-1:0] rd_data;
  logic [LEVEL_W-1:0] rd_lvl;
  logic [LEVEL_W-1:0] faded;
  logic               light_hit;
  logic [LEVEL_W-1:0] lvl;
  logic [LEVEL_W+7:0] green_wide;
  logic [8:0]         green9;
  logic [GREEN_W-1:0] green;
  logic               wr_en;

  // The whole pipeline advances only when the output register can take a result
  assign adv        = !out_valid_r || out_ready;
  assign rd_en      = (state_r == SW_ISSUE) && adv;
  assign last_issue = issue_idx_r == IDX_W'(LED_COUNT - 1);
  assign last2      = idx2_r == IDX_W'(LED_COUNT - 1);
  assign wr_en      = adv && v2_r;

  lcc_trail_mem #(
    .DEPTH  (LED_COUNT),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (issue_idx_r),
    .rd_data_r (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (idx2_r),
    .wr_data   (lvl)
  );

  always_comb begin
    // A cleared tick reads every entry as dark
    rd_lvl     = ctl.clear ? '0 : rd_data;
    faded      = prod_r[PROD_W-1:FADE_W];
    light_hit  = ctl.light_en && (HEAD_W'(idx2_r) == light_idx);
    if (light_hit) begin
      lvl = FULL_LEVEL;
    end else if (faded < {1'b0, zero_thr}) begin
      lvl = '0;
    end else begin
      lvl = faded;
    end
    green_wide = {lvl, 8'h00} - {8'h00, lvl};
    green9     = green_wide[LEVEL_W+7:FADE_W];
    green      = green9[8] ? 8'hFF : green9[7:0];
  end

  always_comb begin
    state_nxt     = state_r;
    issue_idx_nxt = issue_idx_r;
    case (state_r)
      SW_IDLE: begin
        if (start) begin
          state_nxt     = SW_ISSUE;
          issue_idx_nxt = '0;
        end
      end
      SW_ISSUE: begin
        if (adv) begin
          issue_idx_nxt = issue_idx_r + IDX_W'(1);
          if (last_issue) begin
            state_nxt = SW_FLUSH;
          end
        end
      end
      SW_FLUSH: begin
        if (wr_en && last2) begin
          state_nxt = SW_FINISH;
        end
      end
      SW_FINISH: begin
        state_nxt = SW_IDLE;
      end
      default: begin
        state_nxt = SW_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SW_IDLE;
      issue_idx_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      any_lit_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_idx_r <= issue_idx_nxt;
      if (adv) begin
        v1_r        <= rd_en;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
      end
      if (start) begin
        any_lit_r <= 1'b0;
      end else if (wr_en && (lvl != '0)) begin
        any_lit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r <= issue_idx_r;
      idx2_r <= idx1_r;
      prod_r <= PROD_W'(rd_lvl) * PROD_W'(fade_mult);
      if (v2_r) begin
        out_pos_r   <= remap_pos(LIDX_W'(idx2_r));
        out_green_r <= green;
        out_last_r  <= last2;
      end
    end
  end

  assign stat.done    = state_r == SW_FINISH;
  assign stat.any_lit = any_lit_r;
  assign busy         = state_r != SW_IDLE;

endmodule

/* design/led_comet_trail_chase_core.sv */
// Comet chase with a fading trail: top level, configuration registers and handshakes.
// Depends on lcc_pkg, lcc_head_ctl, lcc_sweep (with lcc_trail_mem), assert_macros.svh.
//
// Usage: each transaction on the in_ channel is one animation tick; in_restart set
// clears trail, head, phase and pause state before that tick is worked. Every tick
// yields LED_COUNT transactions on the out_ channel in logical LED order, each with
// the physical position, the green level, and out_last_led set on the final one.
// The cfg_ port writes one register per cycle at cfg_index; write only while idle.
// After a tick is accepted, its first result passes the sweep state, RAM read, product and
// output registers. A tick is one sweep over the single read port of the trail RAM, which
// visits each LED once; the next tick is accepted only once the sweep is back to idle.
// in_ready rises the cycle after the last result of a tick enters the output
// register, so the next tick can be accepted while that result still waits.
// A stalled receiver freezes the whole sweep pipeline; nothing is dropped.
// Reset: registers return to their defaults and the trail reads as dark on the
// first tick, with no clearing pass needed.
`include "assert_macros.svh"

module led_comet_trail_chase_core import lcc_pkg::*; #(
  parameter int LED_COUNT = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_W-1:0]      out_led_position,
  output logic [GREEN_W-1:0]    out_green_level,
  output logic                  out_last_led,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int HEAD_W = $clog2(LED_COUNT + 1);

  logic [PHASE_W-1:0] step_period_r;
  logic [PHASE_W-1:0] pause_length_r;
  logic [FADE_W-1:0]  fade_mult_r;
  logic [FADE_W-1:0]  zero_thr_r;

  logic               start;
  logic               busy;
  tick_ctl_t          tick_ctl;
  logic [HEAD_W-1:0]  light_idx;
  sweep_stat_t        stat;

  assign in_ready = !busy;
  assign start    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r  <= STEP_PERIOD_RST;
      pause_length_r <= PAUSE_LENGTH_RST;
      fade_mult_r    <= FADE_MULTIPLIER_RST;
      zero_thr_r     <= ZERO_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STEP_PERIOD:     step_period_r  <= cfg_wdata[PHASE_W-1:0];
        CFG_PAUSE_LENGTH:    pause_length_r <= cfg_wdata[PHASE_W-1:0];
        CFG_FADE_MULTIPLIER: fade_mult_r    <= cfg_wdata[FADE_W-1:0];
        CFG_ZERO_THRESHOLD:  zero_thr_r     <= cfg_wdata[FADE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lcc_head_ctl #(
    .LED_COUNT (LED_COUNT),
    .HEAD_W    (HEAD_W)
  ) u_head (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .restart      (in_restart),
    .step_period  (step_period_r),
    .pause_length (pause_length_r),
    .stat         (stat),
    .ctl_r        (tick_ctl),
    .light_idx_r  (light_idx)
  );

  lcc_sweep #(
    .LED_COUNT (LED_COUNT),
    .IDX_W     (IDX_W),
    .HEAD_W    (HEAD_W)
  ) u_sweep (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .ctl         (tick_ctl),
    .light_idx   (light_idx),
    .fade_mult   (fade_mult_r),
    .zero_thr    (zero_thr_r),
    .out_ready   (out_ready),
    .out_valid_r (out_valid),
    .out_pos_r   (out_led_position),
    .out_green_r (out_green_level),
    .out_last_r  (out_last_led),
    .stat        (stat),
    .busy        (busy)
  );

  `LCC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `LCC_ASSERT_IMP(a_light_in_range, tick_ctl.light_en, light_idx < HEAD_W'(LED_COUNT))
  `LCC_ASSERT_IMP(a_idle_holds_only_last, in_ready && out_valid, out_last_led)

endmodule

/* dv/led_comet_trail_chase_core_test.sv */
// Self-checking testbench for led_comet_trail_chase_core: directed tick table, then random ticks.
// Depends on lcc_pkg and the comet chase RTL; the checker carries its own model of the trail.
module led_comet_trail_chase_core_test;
  import lcc_pkg::*;

  localparam int LED_COUNT     = 11;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX    = 10;
  localparam int PHASE_TICKS   = 26;
  localparam int NO_TYPED      = -1;
  localparam int ALL_DARK      = LED_COUNT;
  localparam int N_ROWS        = 35;

  localparam logic [POS_W-1:0] PHYS_POS [LED_COUNT] =
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd10};

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [GREEN_W-1:0] green;
    logic               last;
  } led_result_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic                 restart;
    int                   full_led;  // LED expected at full with all others dark
    logic [CFG_IDX_W-1:0] reg_idx;
    int                   reg_val;
  } chase_row_t;

  chase_row_t directed_rows [N_ROWS] = '{
    '{ROW_TICK, 1'b0, 0,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, NO_TYPED, CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, NO_TYPED, CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, NO_TYPED, CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, NO_TYPED, CFG_STEP_PERIOD,     0},
    // shorter period while the phase count sits above it
    '{ROW_CFG,  1'b0, NO_TYPED, CFG_STEP_PERIOD,     2},
    '{ROW_TICK, 1'b0, NO_TYPED, CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, NO_TYPED, CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b1, 0,        CFG_STEP_PERIOD,     0},
    // no fade memory, one LED per tick: the comet is a single lit LED
    '{ROW_CFG,  1'b0, NO_TYPED, CFG_FADE_MULTIPLIER, 0},
    '{ROW_CFG,  1'b0, NO_TYPED, CFG_ZERO_THRESHOLD,  0},
    '{ROW_CFG,  1'b0, NO_TYPED, CFG_STEP_PERIOD,     1},
    '{ROW_CFG,  1'b0, NO_TYPED, CFG_PAUSE_LENGTH,    0},
    '{ROW_TICK, 1'b1, 1,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 2,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 3,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 4,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 5,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 6,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 7,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 8,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 9,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 10,       CFG_STEP_PERIOD,     0},
    // head runs off the end, then the tick that leaves waiting stays dark
    '{ROW_TICK, 1'b0, ALL_DARK, CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, ALL_DARK, CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 1,        CFG_STEP_PERIOD,     0},
    // zero period behaves as one
    '{ROW_CFG,  1'b0, NO_TYPED, CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b1, 1,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, 2,        CFG_STEP_PERIOD,     0},
    '{ROW_CFG,  1'b0, NO_TYPED, CFG_STEP_PERIOD,     255},
    '{ROW_CFG,  1'b0, NO_TYPED, CFG_PAUSE_LENGTH,    255},
    '{ROW_CFG,  1'b0, NO_TYPED, CFG_FADE_MULTIPLIER, 32767},
    '{ROW_CFG,  1'b0, NO_TYPED, CFG_ZERO_THRESHOLD,  32767},
    '{ROW_TICK, 1'b1, 0,        CFG_STEP_PERIOD,     0},
    '{ROW_TICK, 1'b0, NO_TYPED, CFG_STEP_PERIOD,     0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [POS_W-1:0]      out_led_position;
  logic [GREEN_W-1:0]    out_green_level;
  logic                  out_last_led;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_STEP_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Trail model state and register copies
  logic [LEVEL_W-1:0] trail_lvl [LED_COUNT];
  logic [POS_W-1:0]   head_pos;
  logic               comet_waiting;
  logic [PHASE_W-1:0] phase_cnt;
  logic [PHASE_W-1:0] pause_cnt;
  logic [PHASE_W-1:0] step_per;
  logic [PHASE_W-1:0] pause_len;
  logic [FADE_W-1:0]  fade_mult;
  logic [FADE_W-1:0]  dark_thresh;

  led_result_t pending_leds [$];
  int          fail_count = 0;
  int          mismatch_count = 0;
  int          ticks_sent = 0;
  int          results_seen = 0;
  int          reg_writes = 0;
  int          cycle_count = 0;
  logic        steady_flow = 1'b0;

  led_comet_trail_chase_core #(.LED_COUNT(LED_COUNT)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_position (out_led_position),
    .out_green_level  (out_green_level),
    .out_last_led     (out_last_led),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function void clear_trail();
    for (int i = 0; i < LED_COUNT; i++) trail_lvl[i] = '0;
    head_pos      = '0;
    comet_waiting = 1'b0;
    phase_cnt     = '0;
    pause_cnt     = '0;
  endfunction

  // Advance the trail by one tick and queue the LED levels it produces.
  function void predict_tick(input logic restart, input int full_led);
    int unsigned prod;
    int unsigned lvl;
    logic        any_lit;
    led_result_t res;
    if (restart) clear_trail();
    for (int i = 0; i < LED_COUNT; i++) begin
      prod = 32'(trail_lvl[i]) * 32'(fade_mult);
      lvl  = prod >> 15;
      if (lvl < 32'(dark_thresh)) lvl = 0;
      trail_lvl[i] = LEVEL_W'(lvl);
    end
    if (!comet_waiting) begin
      phase_cnt = phase_cnt + 8'd1;
      if (phase_cnt >= step_per) begin
        phase_cnt = '0;
        head_pos  = head_pos + 4'd1;
        if (head_pos >= POS_W'(LED_COUNT)) begin
          head_pos      = POS_W'(LED_COUNT);
          comet_waiting = 1'b1;
        end
      end
      if (head_pos < POS_W'(LED_COUNT)) trail_lvl[head_pos] = FULL_LEVEL;
    end else begin
      any_lit = 1'b0;
      for (int i = 0; i < LED_COUNT; i++) if (trail_lvl[i] != '0) any_lit = 1'b1;
      if (!any_lit) begin
        if (pause_cnt < pause_len) begin
          pause_cnt = pause_cnt + 8'd1;
        end else begin
          comet_waiting = 1'b0;
          head_pos      = '0;
          phase_cnt     = '0;
          pause_cnt     = '0;
        end
      end
    end
    for (int i = 0; i < LED_COUNT; i++) begin
      res.pos  = PHYS_POS[i];
      res.last = (i == LED_COUNT - 1);
      if (full_led != NO_TYPED) begin
        res.green = (i == full_led) ? 8'd255 : 8'd0;
      end else begin
        lvl = (32'(trail_lvl[i]) * 32'd255) >> 15;
        if (lvl > 255) lvl = 255;
        res.green = GREEN_W'(lvl);
      end
      pending_leds.push_back(res);
    end
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      CFG_STEP_PERIOD:     step_per    = PHASE_W'(val);
      CFG_PAUSE_LENGTH:    pause_len   = PHASE_W'(val);
      CFG_FADE_MULTIPLIER: fade_mult   = FADE_W'(val);
      CFG_ZERO_THRESHOLD:  dark_thresh = FADE_W'(val);
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_tick(input logic restart, input int full_led);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    predict_tick(restart, full_led);
    ticks_sent++;
  endtask

  // Hold off new ticks until every queued LED result has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: stall a random number of cycles before taking each transaction, except in steady flow.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    led_result_t exp_led;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_leds.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected LED transaction: pos %0d green %0d last %0b",
                   out_led_position, out_green_level, out_last_led);
      end else begin
        exp_led = pending_leds.pop_front();
        if (out_led_position !== exp_led.pos || out_green_level !== exp_led.green ||
            out_last_led !== exp_led.last) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("LED mismatch at cycle %0d: pos %0d/%0d green %0d/%0d last %0b/%0b",
                     cycle_count, out_led_position, exp_led.pos, out_green_level,
                     exp_led.green, out_last_led, exp_led.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d LED results outstanding", pending_leds.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    step_per    = STEP_PERIOD_RST;
    pause_len   = PAUSE_LENGTH_RST;
    fade_mult   = FADE_MULTIPLIER_RST;
    dark_thresh = ZERO_THRESHOLD_RST;
    clear_trail();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        drain_results();
        cfg_write(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      end else begin
        send_tick(directed_rows[r].restart, directed_rows[r].full_led);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      cfg_write(CFG_STEP_PERIOD, (ph == 3) ? $urandom_range(1, 12) : $urandom_range(1, 3));
      cfg_write(CFG_PAUSE_LENGTH, $urandom_range(0, 6));
      cfg_write(CFG_FADE_MULTIPLIER, $urandom_range(4096, 32767));
      cfg_write(CFG_ZERO_THRESHOLD, $urandom_range(0, 4095));
      steady_flow = (ph == 1);
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if (ph == 2 && k == PHASE_TICKS / 2) drain_results();
        send_tick($urandom_range(0, 24) == 0, NO_TYPED);
      end
    end
    steady_flow = 1'b0;

    drain_results();
    fail_count += pending_leds.size();
    $display("Covered %0d ticks (%0d directed rows), %0d LED results, %0d register writes.",
             ticks_sent, N_ROWS, results_seen, reg_writes);
    $display("Mismatches: %0d", mismatch_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
